>>> rtl/core/dq_current_state_observer_assert.svh
`ifndef DQ_CURRENT_STATE_OBSERVER_ASSERT_SVH
`define DQ_CURRENT_STATE_OBSERVER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DQSO_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("dqso assertion failed");

// Next-cycle implication, disabled while in reset.
`define DQSO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("dqso assertion failed");

`endif

>>> rtl/core/dqso_pkg.sv
`default_nettype none
package dqso_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DW = 32;
	localparam int OPW = 34;
	localparam int ACCW = 64;
	localparam int PRODW = 2 * OPW;

	localparam int IDXW = 3;
	localparam logic [IDXW-1:0] REG_TS = 3'd0;
	localparam logic [IDXW-1:0] REG_R_OVER_L = 3'd1;
	localparam logic [IDXW-1:0] REG_INV_L = 3'd2;
	localparam logic [IDXW-1:0] REG_PSI_OVER_L = 3'd3;
	localparam logic [IDXW-1:0] REG_POLE = 3'd4;

	localparam logic [DW-1:0] TS_RESET = 32'd429497;

	localparam logic signed [ACCW-1:0] SAT_MAX = {{(ACCW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [ACCW-1:0] SAT_MIN = {{(ACCW-DW+1){1'b1}}, {(DW-1){1'b0}}};

	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic load;
		logic sub;
		logic sat_term;
		logic shift32;
	} mac_ctl_t;

	function automatic logic signed [DW-1:0] sat32(input logic signed [ACCW-1:0] v);
		logic signed [DW-1:0] r;
		if (v > SAT_MAX) begin
			r = SAT_MAX[DW-1:0];
		end else if (v < SAT_MIN) begin
			r = SAT_MIN[DW-1:0];
		end else begin
			r = v[DW-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/dq_current_state_observer.sv
`default_nettype none
// Cross-coupled d/q current observer with disturbance estimation. One
// transfer in gives one transfer out. A single 34x34 multiplier with a
// 64-bit accumulator runs sixteen multiply steps, each a multiply and an
// accumulate phase, after a setup state for gains and errors. The next
// input is taken only once the result is in the output registers, so an
// output stall holds the input too. in_stall is high while an item is in
// work. Configuration must be written only while idle (not enforced).
module dq_current_state_observer
	import dqso_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [IDXW-1:0]       wr_idx,
	input  wire logic [DW-1:0]         wr_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic signed [DW-1:0]  volt_d,
	input  wire logic signed [DW-1:0]  volt_q,
	input  wire logic signed [DW-1:0]  elec_speed,
	input  wire logic signed [DW-1:0]  meas_d,
	input  wire logic signed [DW-1:0]  meas_q,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [DW-1:0]       est_d,
	output logic signed [DW-1:0]       est_q,
	output logic signed [DW-1:0]       dist_d,
	output logic signed [DW-1:0]       dist_q
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [3:0] STP_P2    = 4'd0;
	localparam logic [3:0] STP_DECAY = 4'd1;
	localparam logic [3:0] STP_G2    = 4'd2;
	localparam logic [3:0] STP_Z2D   = 4'd3;
	localparam logic [3:0] STP_Z2Q   = 4'd4;
	localparam logic [3:0] STP_RD0   = 4'd5;
	localparam logic [3:0] STP_RD1   = 4'd6;
	localparam logic [3:0] STP_RD2   = 4'd7;
	localparam logic [3:0] STP_Z1D0  = 4'd8;
	localparam logic [3:0] STP_Z1D1  = 4'd9;
	localparam logic [3:0] STP_RQ0   = 4'd10;
	localparam logic [3:0] STP_RQ1   = 4'd11;
	localparam logic [3:0] STP_RQ2   = 4'd12;
	localparam logic [3:0] STP_RQ3   = 4'd13;
	localparam logic [3:0] STP_Z1Q0  = 4'd14;
	localparam logic [3:0] STP_Z1Q1  = 4'd15;

	localparam logic signed [ACCW-1:0] ONE = {{(ACCW-1){1'b0}}, 1'b1} << FRAC_BITS;

	// configuration
	logic [DW-1:0]          ts_q;
	logic [DW-2:0]          rl_q;
	logic [DW-2:0]          inv_l_q;
	logic [DW-2:0]          psi_q;
	logic signed [DW-1:0]   pole_q;

	// control
	logic [1:0]             state_q;
	logic [3:0]             step_q;
	logic                   phase_q;
	logic                   out_valid_q;
	logic                   in_xfer;
	logic                   out_load;

	// observer state
	logic signed [DW-1:0]   cur_d_q;
	logic signed [DW-1:0]   cur_q_q;
	logic signed [DW-1:0]   dst_d_q;
	logic signed [DW-1:0]   dst_q_q;

	// captured item and work registers
	logic signed [DW-1:0]   ud_q;
	logic signed [DW-1:0]   uq_q;
	logic signed [DW-1:0]   we_q;
	logic signed [DW-1:0]   fd_q;
	logic signed [DW-1:0]   fq_q;
	logic signed [DW-1:0]   p1d_q;
	logic signed [DW-1:0]   p1q_q;
	logic signed [DW:0]     err_d_q;
	logic signed [DW:0]     err_q_q;
	logic signed [DW-1:0]   tmp_q;
	logic signed [DW:0]     decay_q;
	logic signed [DW-1:0]   g2_q;
	logic signed [DW-1:0]   z1d_q;
	logic signed [DW-1:0]   z1q_q;
	logic signed [DW-1:0]   z2d_q;
	logic signed [DW-1:0]   z2q_q;
	logic signed [DW-1:0]   est_d_q;
	logic signed [DW-1:0]   est_q_q;
	logic signed [DW-1:0]   dist_d_q;
	logic signed [DW-1:0]   dist_q_q;

	// gain setup
	logic signed [ACCW-1:0] we_w;
	logic signed [ACCW-1:0] abs_we;
	logic signed [ACCW-1:0] gain_base;

	// shared unit
	mac_ctl_t               ctl;
	logic signed [OPW-1:0]  op_a;
	logic signed [OPW-1:0]  op_b;
	logic signed [ACCW-1:0] base;
	logic signed [ACCW-1:0] acc_next;
	logic signed [DW-1:0]   acc_sat;

	logic signed [OPW-1:0]  ts_x;
	logic signed [OPW-1:0]  rl_x;
	logic signed [OPW-1:0]  inv_l_x;
	logic signed [OPW-1:0]  psi_x;
	logic signed [OPW-1:0]  pole_x;
	logic signed [OPW-1:0]  tmp_x;
	logic signed [OPW-1:0]  g2_x;
	logic signed [OPW-1:0]  decay_x;
	logic signed [OPW-1:0]  err_d_x;
	logic signed [OPW-1:0]  err_q_x;
	logic signed [OPW-1:0]  ud_x;
	logic signed [OPW-1:0]  uq_x;
	logic signed [OPW-1:0]  we_x;
	logic signed [OPW-1:0]  p1d_x;
	logic signed [OPW-1:0]  p1q_x;
	logic signed [OPW-1:0]  cur_d_x;
	logic signed [OPW-1:0]  cur_q_x;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer = in_valid && !in_stall;
	assign out_load = (state_q == ST_DONE) && !(out_valid_q && out_stall);
	assign out_valid = out_valid_q;
	assign est_d = est_d_q;
	assign est_q = est_q_q;
	assign dist_d = dist_d_q;
	assign dist_q = dist_q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= TS_RESET;
			rl_q <= '0;
			inv_l_q <= '0;
			psi_q <= '0;
			pole_q <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				REG_TS:         ts_q <= wr_data;
				REG_R_OVER_L:   rl_q <= wr_data[DW-2:0];
				REG_INV_L:      inv_l_q <= wr_data[DW-2:0];
				REG_PSI_OVER_L: psi_q <= wr_data[DW-2:0];
				REG_POLE:       pole_q <= $signed(wr_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			phase_q <= 1'b0;
			out_valid_q <= 1'b0;
			cur_d_q <= '0;
			cur_q_q <= '0;
			dst_d_q <= '0;
			dst_q_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						step_q <= step_q + 4'd1;
						if (step_q == STP_Z1Q1) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						cur_d_q <= z1d_q;
						cur_q_q <= z1q_q;
						dst_d_q <= z2d_q;
						dst_q_q <= z2q_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// p1d = -R/L - 2*pole - |we|, p1q = -R/L - 2*pole + |we|
	always_comb begin
		we_w = ACCW'(we_q);
		abs_we = (we_w < 0) ? -we_w : we_w;
		gain_base = -$signed(ACCW'(rl_q)) - (ACCW'(pole_q) <<< 1);
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ud_q <= volt_d;
			uq_q <= volt_q;
			we_q <= elec_speed;
			fd_q <= meas_d;
			fq_q <= meas_q;
		end
		if (state_q == ST_SETUP) begin
			p1d_q <= sat32(gain_base - abs_we);
			p1q_q <= sat32(gain_base + abs_we);
			err_d_q <= $signed({fd_q[DW-1], fd_q}) - $signed({cur_d_q[DW-1], cur_d_q});
			err_q_q <= $signed({fq_q[DW-1], fq_q}) - $signed({cur_q_q[DW-1], cur_q_q});
		end
		if (state_q == ST_RUN && phase_q) begin
			case (step_q)
				STP_P2:    tmp_q <= acc_sat;
				STP_DECAY: decay_q <= acc_next[DW:0];
				STP_G2:    g2_q <= acc_sat;
				STP_Z2D:   z2d_q <= acc_sat;
				STP_Z2Q:   z2q_q <= acc_sat;
				STP_RD2:   tmp_q <= acc_sat;
				STP_Z1D1:  z1d_q <= acc_sat;
				STP_RQ3:   tmp_q <= acc_sat;
				STP_Z1Q1:  z1q_q <= acc_sat;
				default: ;
			endcase
		end
		if (out_load) begin
			est_d_q <= z1d_q;
			est_q_q <= z1q_q;
			dist_d_q <= z2d_q;
			dist_q_q <= z2q_q;
		end
	end

	assign ts_x = $signed({2'b00, ts_q});
	assign rl_x = $signed({3'b000, rl_q});
	assign inv_l_x = $signed({3'b000, inv_l_q});
	assign psi_x = $signed({3'b000, psi_q});
	assign pole_x = OPW'(pole_q);
	assign tmp_x = OPW'(tmp_q);
	assign g2_x = OPW'(g2_q);
	assign decay_x = OPW'(decay_q);
	assign err_d_x = OPW'(err_d_q);
	assign err_q_x = OPW'(err_q_q);
	assign ud_x = OPW'(ud_q);
	assign uq_x = OPW'(uq_q);
	assign we_x = OPW'(we_q);
	assign p1d_x = OPW'(p1d_q);
	assign p1q_x = OPW'(p1q_q);
	assign cur_d_x = OPW'(cur_d_q);
	assign cur_q_x = OPW'(cur_q_q);

	always_comb begin
		op_a = '0;
		op_b = '0;
		base = '0;
		ctl.mul_en = (state_q == ST_RUN) && !phase_q;
		ctl.acc_en = (state_q == ST_RUN) && phase_q;
		ctl.load = 1'b0;
		ctl.sub = 1'b0;
		ctl.sat_term = 1'b0;
		ctl.shift32 = 1'b0;
		case (step_q)
			STP_P2: begin
				op_a = pole_x; op_b = pole_x;
				ctl.load = 1'b1; ctl.sat_term = 1'b1;
			end
			STP_DECAY: begin
				op_a = ts_x; op_b = rl_x; base = ONE;
				ctl.load = 1'b1; ctl.sub = 1'b1; ctl.shift32 = 1'b1;
			end
			STP_G2: begin
				op_a = ts_x; op_b = tmp_x;
				ctl.load = 1'b1; ctl.shift32 = 1'b1;
			end
			STP_Z2D: begin
				op_a = g2_x; op_b = err_d_x; base = ACCW'(dst_d_q);
				ctl.load = 1'b1; ctl.sat_term = 1'b1;
			end
			STP_Z2Q: begin
				op_a = g2_x; op_b = err_q_x; base = ACCW'(dst_q_q);
				ctl.load = 1'b1; ctl.sat_term = 1'b1;
			end
			STP_RD0: begin
				op_a = ud_x; op_b = inv_l_x; base = ACCW'(dst_d_q);
				ctl.load = 1'b1; ctl.sat_term = 1'b1;
			end
			STP_RD1: begin
				op_a = we_x; op_b = cur_q_x;
				ctl.sat_term = 1'b1;
			end
			STP_RD2: begin
				op_a = p1d_x; op_b = err_d_x;
				ctl.sat_term = 1'b1;
			end
			STP_Z1D0: begin
				op_a = ts_x; op_b = tmp_x;
				ctl.load = 1'b1; ctl.shift32 = 1'b1;
			end
			STP_Z1D1: begin
				op_a = cur_d_x; op_b = decay_x;
			end
			STP_RQ0: begin
				op_a = uq_x; op_b = inv_l_x; base = ACCW'(dst_q_q);
				ctl.load = 1'b1; ctl.sat_term = 1'b1;
			end
			STP_RQ1: begin
				op_a = we_x; op_b = cur_d_x;
				ctl.sub = 1'b1; ctl.sat_term = 1'b1;
			end
			STP_RQ2: begin
				op_a = p1q_x; op_b = err_q_x;
				ctl.sat_term = 1'b1;
			end
			STP_RQ3: begin
				op_a = psi_x; op_b = we_x;
				ctl.sub = 1'b1; ctl.sat_term = 1'b1;
			end
			STP_Z1Q0: begin
				op_a = ts_x; op_b = tmp_x;
				ctl.load = 1'b1; ctl.shift32 = 1'b1;
			end
			STP_Z1Q1: begin
				op_a = cur_q_x; op_b = decay_x;
			end
			default: ;
		endcase
	end

	dqso_mac #(
		.FRAC_BITS(FRAC_BITS)
	) u_mac (
		.clk      (clk),
		.ctl      (ctl),
		.op_a     (op_a),
		.op_b     (op_b),
		.base     (base),
		.acc_next (acc_next),
		.acc_sat  (acc_sat)
	);

`include "dq_current_state_observer_assert.svh"

	`DQSO_ASSERT_NEXT(a_busy_after_xfer, in_xfer, in_stall && state_q == ST_SETUP)
	`DQSO_ASSERT_NOW(a_step_idle, state_q != ST_RUN, step_q == STP_P2 && !phase_q)
	`DQSO_ASSERT_NEXT(a_setup_to_run, state_q == ST_SETUP, state_q == ST_RUN && step_q == STP_P2)
	`DQSO_ASSERT_NEXT(a_done_loads, out_load, out_valid && state_q == ST_IDLE)

endmodule
`default_nettype wire

>>> rtl/core/dqso_mac.sv
`default_nettype none
module dqso_mac
	import dqso_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire mac_ctl_t               ctl,
	input  wire logic signed [OPW-1:0]  op_a,
	input  wire logic signed [OPW-1:0]  op_b,
	input  wire logic signed [ACCW-1:0] base,
	output logic signed [ACCW-1:0]      acc_next,
	output logic signed [DW-1:0]        acc_sat
);

	logic signed [PRODW-1:0] prod_full;
	logic signed [ACCW-1:0]  prod_s1;
	logic signed [ACCW-1:0]  acc_q;
	logic signed [ACCW-1:0]  shifted;
	logic signed [ACCW-1:0]  term;
	logic signed [ACCW-1:0]  start;
	logic signed [DW-1:0]    term_sat;

	assign prod_full = op_a * op_b;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= prod_full[ACCW-1:0];
		end
		if (ctl.acc_en) begin
			acc_q <= acc_next;
		end
	end

	// floor shift of the product, then optional clamp of the term
	always_comb begin
		shifted = ctl.shift32 ? (prod_s1 >>> 32) : (prod_s1 >>> FRAC_BITS);
		term_sat = sat32(shifted);
		term = ctl.sat_term ? ACCW'(term_sat) : shifted;
		start = ctl.load ? base : acc_q;
		acc_next = ctl.sub ? (start - term) : (start + term);
		acc_sat = sat32(acc_next);
	end

endmodule
`default_nettype wire

>>> tb/dq_current_state_observer_tb.sv
module dq_current_state_observer_tb
	import dqso_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int unsigned VOLT_SPAN = 400 << 16;
	localparam int unsigned SPEED_SPAN = 3000 << 16;
	localparam int unsigned CUR_SPAN = 60 << 16;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [DW-1:0] volt_d;
		logic signed [DW-1:0] volt_q;
		logic signed [DW-1:0] elec_speed;
		logic signed [DW-1:0] meas_d;
		logic signed [DW-1:0] meas_q;
	} obs_in_t;

	typedef struct packed {
		logic signed [DW-1:0] est_d;
		logic signed [DW-1:0] est_q;
		logic signed [DW-1:0] dist_d;
		logic signed [DW-1:0] dist_q;
	} obs_out_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [IDXW-1:0] wr_idx = REG_TS;
	logic [DW-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	obs_in_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DW-1:0] est_d, est_q, dist_d, dist_q;

	// observer shadow: configuration and state
	longint cfg_ts = longint'(TS_RESET);
	longint cfg_rl = 0;
	longint cfg_invl = 0;
	longint cfg_psil = 0;
	longint cfg_pole = 0;
	longint st_cur_d = 0;
	longint st_cur_q = 0;
	longint st_dist_d = 0;
	longint st_dist_q = 0;

	obs_in_t item_q[$];
	obs_out_t pending_estimates[$];
	obs_out_t want;
	int errors = 0;
	int burst_left = 0;
	int gap_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int mode_left = 0;
	int idle_cycles = 0;

	dq_current_state_observer #(.FRAC_BITS(FRAC)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_idx(wr_idx),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.volt_d(in_item.volt_d),
		.volt_q(in_item.volt_q),
		.elec_speed(in_item.elec_speed),
		.meas_d(in_item.meas_d),
		.meas_q(in_item.meas_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.est_d(est_d),
		.est_q(est_q),
		.dist_d(dist_d),
		.dist_q(dist_q)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint clamp32(longint v);
		if (v > S32_MAX) begin
			return S32_MAX;
		end else if (v < S32_MIN) begin
			return S32_MIN;
		end
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return clamp32((a * b) >>> FRAC);
	endfunction

	// advance both axes one control period, floor rounding on every shift
	function automatic obs_out_t predict_estimates(obs_in_t it);
		longint ud, uq, we, fd, fq, abs_we, base, p1d, p1q, p2, decay, g2;
		longint err_d, err_q, rate_d, rate_q, z1d, z1q, z2d, z2q;
		obs_out_t r;
		ud = longint'($signed(it.volt_d));
		uq = longint'($signed(it.volt_q));
		we = longint'($signed(it.elec_speed));
		fd = longint'($signed(it.meas_d));
		fq = longint'($signed(it.meas_q));
		abs_we = (we < 0) ? -we : we;
		base = -cfg_rl - 2 * cfg_pole;
		p1d = clamp32(base - abs_we);
		p1q = clamp32(base + abs_we);
		p2 = qmul(cfg_pole, cfg_pole);
		decay = (longint'(1) <<< FRAC) - ((cfg_ts * cfg_rl) >>> 32);
		g2 = (cfg_ts * p2) >>> 32;
		err_d = fd - st_cur_d;
		err_q = fq - st_cur_q;
		rate_d = clamp32(qmul(ud, cfg_invl) + qmul(we, st_cur_q) + st_dist_d
			+ qmul(p1d, err_d));
		rate_q = clamp32(qmul(uq, cfg_invl) - qmul(we, st_cur_d) + st_dist_q
			+ qmul(p1q, err_q) - qmul(cfg_psil, we));
		z1d = clamp32(((st_cur_d * decay) >>> FRAC) + ((rate_d * cfg_ts) >>> 32));
		z1q = clamp32(((st_cur_q * decay) >>> FRAC) + ((rate_q * cfg_ts) >>> 32));
		z2d = clamp32(st_dist_d + qmul(g2, err_d));
		z2q = clamp32(st_dist_q + qmul(g2, err_q));
		st_cur_d = z1d;
		st_cur_q = z1q;
		st_dist_d = z2d;
		st_dist_q = z2q;
		r.est_d = z1d[DW-1:0];
		r.est_q = z1q[DW-1:0];
		r.dist_d = z2d[DW-1:0];
		r.dist_q = z2q[DW-1:0];
		return r;
	endfunction

	function automatic void check_field(string name, logic signed [DW-1:0] exp_v,
			logic signed [DW-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	function automatic obs_in_t make_item(logic [DW-1:0] vd, logic [DW-1:0] vq,
			logic [DW-1:0] we, logic [DW-1:0] md, logic [DW-1:0] mq);
		obs_in_t it;
		it.volt_d = vd;
		it.volt_q = vq;
		it.elec_speed = we;
		it.meas_d = md;
		it.meas_q = mq;
		return it;
	endfunction

	// mostly plausible operating values, some full-range and corner values
	function automatic logic [DW-1:0] pick_value(int unsigned span);
		logic [DW-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: v = $urandom_range(0, 2 * span) - span;
			6, 7: v = $urandom;
			8: begin
				case ($urandom_range(0, 4))
					0: v = 32'h0000_0000;
					1: v = 32'h0000_0001;
					2: v = 32'hFFFF_FFFF;
					3: v = 32'h7FFF_FFFF;
					default: v = 32'h8000_0000;
				endcase
			end
			default: v = $urandom_range(0, 511) - 256;
		endcase
		return v;
	endfunction

	function automatic obs_in_t random_item();
		return make_item(pick_value(VOLT_SPAN), pick_value(VOLT_SPAN),
			pick_value(SPEED_SPAN), pick_value(CUR_SPAN), pick_value(CUR_SPAN));
	endfunction

	task automatic reg_write(logic [IDXW-1:0] idx, logic [DW-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= val;
	endtask

	task automatic set_config(logic [DW-1:0] ts_v, logic [DW-1:0] rl_v,
			logic [DW-1:0] invl_v, logic [DW-1:0] psil_v, logic [DW-1:0] pole_v);
		reg_write(REG_TS, ts_v);
		reg_write(REG_R_OVER_L, rl_v);
		reg_write(REG_INV_L, invl_v);
		reg_write(REG_PSI_OVER_L, psil_v);
		reg_write(REG_POLE, pole_v);
		@(posedge clk);
		wr_en <= 1'b0;
		cfg_ts = longint'(ts_v);
		cfg_rl = longint'(rl_v[30:0]);
		cfg_invl = longint'(invl_v[30:0]);
		cfg_psil = longint'(psil_v[30:0]);
		cfg_pole = longint'($signed(pole_v));
	endtask

	// sampled away from the rising edge so driver and monitor updates have settled
	task automatic wait_idle();
		@(negedge clk);
		while (item_q.size() != 0 || in_valid || pending_estimates.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// sender: bursts of transfers separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (item_q.size() != 0) begin
				in_item <= item_q.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					case ($urandom_range(0, 4))
						0, 1: gap_left <= 0;
						2, 3: gap_left <= $urandom_range(1, 5);
						default: gap_left <= $urandom_range(6, 60);
					endcase
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches between modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= STALL_NONE;
			mode_left <= 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
				default: out_stall <= ~out_stall;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pending_estimates.push_back(predict_estimates(in_item));
			end
			if (out_valid && !out_stall) begin
				if (pending_estimates.size() == 0) begin
					$display("%0t: unexpected result transfer: est_d %0d est_q %0d",
						$time, est_d, est_q);
					errors++;
				end else begin
					want = pending_estimates.pop_front();
					check_field("est_d", want.est_d, est_d);
					check_field("est_q", want.est_q, est_q);
					check_field("dist_d", want.dist_d, dist_d);
					check_field("dist_q", want.dist_q, dist_q);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration
		repeat (3) item_q.push_back(random_item());
		wait_idle();

		// nominal motor, corner inputs
		set_config(32'd429497, 32'd100 << 16, 32'd500 << 16, 32'd50 << 16,
			-(32'd1000 << 16));
		item_q.push_back(make_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
		item_q.push_back(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF));
		item_q.push_back(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000));
		item_q.push_back(make_item(32'h0064_0000, 32'hFF9C_0000, 32'h8000_0000,
			32'h0001_0000, 32'hFFFF_0000));
		item_q.push_back(make_item(32'h0064_0000, 32'h00C8_0000, 32'h7FFF_FFFF,
			32'hFFFF_0000, 32'h0001_0000));
		item_q.push_back(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
			32'h8000_0000, 32'h7FFF_FFFF));
		item_q.push_back(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h03E8_0000,
			32'h7FFF_FFFF, 32'h8000_0000));
		item_q.push_back(make_item(32'h1, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h1));
		item_q.push_back(make_item(32'h00C8_0000, 32'h0096_0000, 32'h01F4_0000,
			32'h000A_0000, 32'h0014_0000));
		item_q.push_back(make_item(32'hFF38_0000, 32'hFF6A_0000, 32'hFE0C_0000,
			32'hFFF6_0000, 32'hFFEC_0000));
		item_q.push_back(make_item(32'h0, 32'h0, 32'h0BB8_0000, 32'h0, 32'h0));
		item_q.push_back(make_item(32'h0, 32'h0, 32'hF448_0000, 32'h0, 32'h0));
		wait_idle();

		// every register at its top, most negative pole; upper bits ignored
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h8000_0000);
		item_q.push_back(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF));
		item_q.push_back(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000));
		item_q.push_back(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF));
		item_q.push_back(make_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000));
		item_q.push_back(make_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
		item_q.push_back(random_item());
		wait_idle();

		// zero period and gains, largest positive pole
		set_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF);
		item_q.push_back(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF));
		item_q.push_back(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000));
		repeat (2) item_q.push_back(random_item());
		wait_idle();

		for (int ph = 0; ph < 10; ph++) begin
			if ($urandom_range(0, 3) == 0) begin
				set_config($urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				set_config($urandom_range(42950, 4294967), $urandom_range(1, 2000) << 16,
					$urandom_range(10, 5000) << 16, $urandom_range(1, 500) << 16,
					-($urandom_range(100, 5000) << 16));
			end
			repeat (103) item_q.push_back(random_item());
			wait_idle();
		end

		repeat (40) @(posedge clk);
		if (errors == 0 && pending_estimates.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> dq_current_state_observer.f
+incdir+rtl/core
rtl/core/dqso_pkg.sv
rtl/core/dqso_mac.sv
rtl/core/dq_current_state_observer.sv
tb/dq_current_state_observer_tb.sv
